>>> hw/rtl/blkg_pkg.sv
// ============================================================================
// blkg_pkg - shared definitions for the boot latch / memory / keypad glue
// Operation codes, port and flag numbers, memory sizes and the structs that
// travel between the glue submodules.
// ============================================================================
package blkg_pkg;

    // Memory sizes (bytes) and derived address widths
    localparam int RAM_BYTES = 4096;
    localparam int ROM_BYTES = 512;
    localparam int RAM_AW    = $clog2(RAM_BYTES);
    localparam int ROM_AW    = $clog2(ROM_BYTES);

    // Operation codes
    localparam logic [3:0] OP_READ    = 4'd0;
    localparam logic [3:0] OP_WRITE   = 4'd1;
    localparam logic [3:0] OP_LOAD    = 4'd2;
    localparam logic [3:0] OP_OUTPUT  = 4'd3;
    localparam logic [3:0] OP_FLAG    = 4'd4;
    localparam logic [3:0] OP_KEY_DN  = 4'd5;
    localparam logic [3:0] OP_KEY_UP  = 4'd6;
    localparam logic [3:0] OP_MONITOR = 4'd7;
    localparam logic [3:0] OP_RESET   = 4'd8;

    // Output ports and external flags
    localparam logic [2:0] PORT_KEY_COLUMN = 3'd2;
    localparam logic [2:0] PORT_BOOT_CLEAR = 3'd4;
    localparam logic [2:0] FLAG_KEYPAD     = 3'd3;
    localparam logic [2:0] FLAG_MONITOR    = 3'd4;

    localparam logic [7:0] BYTE_UNMAPPED       = 8'hFF;
    localparam logic [7:0] MONITOR_PULSE_RESET = 8'd40;

    // Read data source
    localparam logic [1:0] SRC_NONE = 2'd0;
    localparam logic [1:0] SRC_RAM  = 2'd1;
    localparam logic [1:0] SRC_ROM  = 2'd2;

    typedef struct packed {
        logic [3:0]  operation;
        logic [15:0] address;
        logic [7:0]  data;
        logic [2:0]  port_number;
        logic [2:0]  flag_number;
        logic [3:0]  key_index;
    } item_t;

    typedef struct packed {
        logic              ram_we;
        logic              ram_re;
        logic [RAM_AW-1:0] ram_addr;
        logic              rom_we;
        logic              rom_re;
        logic [ROM_AW-1:0] rom_addr;
        logic [1:0]        src;
    } mem_ctl_t;

endpackage

>>> hw/rtl/blkg_ifs.sv
// ============================================================================
// blkg_ifs - channel interfaces of the glue block
// Command, response and configuration channels, each valid/ready.
// ============================================================================
interface blkg_cmd_if;
    logic        valid;
    logic        ready;
    logic [3:0]  operation;
    logic [15:0] address;
    logic [7:0]  data;
    logic [2:0]  port_number;
    logic [2:0]  flag_number;
    logic [3:0]  key_index;

    modport source (output valid, operation, address, data, port_number, flag_number,
                    key_index, input ready);
    modport sink (input valid, operation, address, data, port_number, flag_number,
                  key_index, output ready);
endinterface

interface blkg_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;
    logic       flag_level;

    modport source (output valid, read_data, flag_level, input ready);
    modport sink (input valid, read_data, flag_level, output ready);
endinterface

interface blkg_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] monitor_pulse_queries;

    modport source (output valid, monitor_pulse_queries, input ready);
    modport sink (input valid, monitor_pulse_queries, output ready);
endinterface

>>> hw/rtl/blkg_ram.sv
// ============================================================================
// blkg_ram - generic single-port RAM
// One read, one write or both per cycle, registered read data, no reset on contents.
// ============================================================================
module blkg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> hw/rtl/blkg_map.sv
// ============================================================================
// blkg_map - memory map decode
// Turns an accepted transaction and the boot latch into RAM/ROM strobes,
// addresses and the read data source.
// ============================================================================
module blkg_map (
    input  logic             accept,
    input  blkg_pkg::item_t  item,
    input  logic             boot_latch,
    output blkg_pkg::mem_ctl_t ctl
);
    import blkg_pkg::*;

    logic [11:0] off12;
    logic [11:0] hi12;
    logic        low;
    logic        ram_ok;
    logic        rom_low_ok;
    logic        rom_high_ok;
    logic        rom_load_ok;

    assign off12       = item.address[11:0];
    assign hi12        = {3'b000, item.address[8:0]};
    assign low         = ~item.address[15];
    assign ram_ok      = {1'b0, off12} < 13'(RAM_BYTES);
    assign rom_low_ok  = {1'b0, off12} < 13'(ROM_BYTES);
    assign rom_high_ok = {1'b0, hi12} < 13'(ROM_BYTES);
    assign rom_load_ok = {1'b0, item.address[14:0]} < 16'(ROM_BYTES);

    always_comb
    begin
        ctl          = '0;
        ctl.src      = SRC_NONE;
        ctl.ram_addr = off12[RAM_AW-1:0];
        ctl.rom_addr = off12[ROM_AW-1:0];
        case (item.operation)
            OP_READ:
            begin
                if (low && !boot_latch)
                begin
                    if (ram_ok)
                    begin
                        ctl.ram_re = accept;
                        ctl.src    = SRC_RAM;
                    end
                end
                else if (low)
                begin
                    if (rom_low_ok)
                    begin
                        ctl.rom_re = accept;
                        ctl.src    = SRC_ROM;
                    end
                end
                else if (rom_high_ok)
                begin
                    ctl.rom_re   = accept;
                    ctl.rom_addr = hi12[ROM_AW-1:0];
                    ctl.src      = SRC_ROM;
                end
            end
            OP_WRITE, OP_LOAD:
            begin
                if (low)
                begin
                    ctl.ram_we = accept && ram_ok;
                end
                else if (item.operation == OP_LOAD && rom_load_ok)
                begin
                    ctl.rom_we   = accept;
                    ctl.rom_addr = item.address[ROM_AW-1:0];
                end
            end
            default:
            begin
                ctl.src = SRC_NONE;
            end
        endcase
    end

endmodule

>>> hw/rtl/blkg_state.sv
// ============================================================================
// blkg_state - latch, keypad and monitor pulse state
// Boot latch, keypad column, key bitmap, monitor pulse counter and the
// pulse length register; answers flag queries.
// ============================================================================
module blkg_state (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            accept,
    input  blkg_pkg::item_t item,
    input  logic            cfg_we,
    input  logic [7:0]      cfg_data,
    output logic            boot_latch,
    output logic            flag_level
);
    import blkg_pkg::*;

    logic        boot_latch_reg, boot_latch_next;
    logic [3:0]  key_column_reg, key_column_next;
    logic [15:0] keys_down_reg, keys_down_next;
    logic [7:0]  monitor_count_reg, monitor_count_next;
    logic [7:0]  pulse_queries_reg, pulse_queries_next;
    logic [15:0] key_bit;

    assign key_bit = 16'b1 << item.key_index;

    always_comb
    begin
        boot_latch_next    = boot_latch_reg;
        key_column_next    = key_column_reg;
        keys_down_next     = keys_down_reg;
        monitor_count_next = monitor_count_reg;
        pulse_queries_next = cfg_we ? cfg_data : pulse_queries_reg;
        flag_level         = 1'b1;
        case (item.flag_number)
            FLAG_KEYPAD:  flag_level = ~keys_down_reg[key_column_reg];
            FLAG_MONITOR: flag_level = (monitor_count_reg != 8'd0);
            default:      flag_level = 1'b1;
        endcase
        if (accept)
        begin
            case (item.operation)
                OP_OUTPUT:
                begin
                    if (item.port_number == PORT_KEY_COLUMN)
                    begin
                        key_column_next = item.data[3:0];
                    end
                    else if (item.port_number == PORT_BOOT_CLEAR)
                    begin
                        boot_latch_next = 1'b0;
                    end
                end
                OP_FLAG:
                begin
                    if (item.flag_number == FLAG_MONITOR && monitor_count_reg != 8'd0)
                    begin
                        monitor_count_next = monitor_count_reg - 8'd1;
                    end
                end
                OP_KEY_DN: keys_down_next = keys_down_reg | key_bit;
                OP_KEY_UP: keys_down_next = keys_down_reg & ~key_bit;
                OP_MONITOR:
                begin
                    monitor_count_next = pulse_queries_reg;
                    boot_latch_next    = 1'b1;
                end
                OP_RESET:  boot_latch_next = 1'b1;
                default:   boot_latch_next = boot_latch_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            boot_latch_reg    <= 1'b1;
            key_column_reg    <= 4'd0;
            keys_down_reg     <= 16'd0;
            monitor_count_reg <= 8'd0;
            pulse_queries_reg <= MONITOR_PULSE_RESET;
        end
        else
        begin
            boot_latch_reg    <= boot_latch_next;
            key_column_reg    <= key_column_next;
            keys_down_reg     <= keys_down_next;
            monitor_count_reg <= monitor_count_next;
            pulse_queries_reg <= pulse_queries_next;
        end
    end

    assign boot_latch = boot_latch_reg;

    a_reset_sets_latch: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (item.operation == OP_RESET || item.operation == OP_MONITOR))
        |=> boot_latch_reg)
        else $error("boot latch not set by reset or monitor key");

    a_port4_clears_latch: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && item.operation == OP_OUTPUT && item.port_number == PORT_BOOT_CLEAR)
        |=> !boot_latch_reg)
        else $error("boot latch not cleared by output port 4");

    a_pulse_decrements: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && item.operation == OP_FLAG && item.flag_number == FLAG_MONITOR
         && monitor_count_reg != 8'd0)
        |=> monitor_count_reg == $past(monitor_count_reg) - 8'd1)
        else $error("monitor pulse count did not step down by one");

endmodule

>>> hw/rtl/boot_latch_memory_and_keypad_glue_core.sv
// ============================================================================
// boot_latch_memory_and_keypad_glue_core - 1802 system glue, top level
// Boot address latch, RAM/ROM memory map, keypad column and monitor pulse
// flags behind valid/ready command, response and configuration channels.
// ============================================================================
// Usage: while cmd.ready is high the block takes one command transaction per
// clock, and it returns exactly one response transaction per command, in
// order. With the response side ready it sustains one transaction per cycle.
// After its command is accepted, a response passes through the registered
// read port of the 4 KB RAM and 512-byte ROM, which captures at the accepting
// edge, and then through the response register. Commands
// keep flowing while a response waits: the memory read stage and the
// response register each hold one transaction, and the command channel
// stalls only when both are full and the response is not taken. RAM and ROM
// contents are not cleared at reset; read only what was written. The
// monitor pulse length register (reset 40) accepts a write every cycle and
// should be written only while no transaction is in flight.
// ============================================================================
module boot_latch_memory_and_keypad_glue_core (
    input logic clk,
    input logic rst_n,
    blkg_cmd_if.sink   cmd,
    blkg_rsp_if.source rsp,
    blkg_cfg_if.sink   cfg
);
    import blkg_pkg::*;

    item_t    item;
    mem_ctl_t ctl;
    logic     accept;
    logic     advance;
    logic     boot_latch;
    logic     flag_level;
    logic [7:0] ram_q;
    logic [7:0] rom_q;
    logic [7:0] read_byte;

    // Stage 1: memory read in flight, flag result captured
    logic       s1_valid_reg, s1_valid_next;
    logic [1:0] s1_src_reg;
    logic       s1_flag_reg;

    // Response register
    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_data_reg;
    logic       out_flag_reg;

    assign item.operation   = cmd.operation;
    assign item.address     = cmd.address;
    assign item.data        = cmd.data;
    assign item.port_number = cmd.port_number;
    assign item.flag_number = cmd.flag_number;
    assign item.key_index   = cmd.key_index;

    // Stage 1 moves on when the response register is empty or being drained.
    assign advance   = s1_valid_reg && (!out_valid_reg || rsp.ready);
    assign cmd.ready = !s1_valid_reg || !out_valid_reg || rsp.ready;
    assign accept    = cmd.valid && cmd.ready;
    assign cfg.ready = 1'b1;

    blkg_map u_map (
        .accept     (accept),
        .item       (item),
        .boot_latch (boot_latch),
        .ctl        (ctl)
    );

    blkg_state u_state (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .item       (item),
        .cfg_we     (cfg.valid && cfg.ready),
        .cfg_data   (cfg.monitor_pulse_queries),
        .boot_latch (boot_latch),
        .flag_level (flag_level)
    );

    // Read data registers only update on an accepted read, so they hold
    // steady while stage 1 waits on the response side.
    blkg_ram #(.WIDTH(8), .DEPTH(RAM_BYTES)) u_ram (
        .clk   (clk),
        .we    (ctl.ram_we),
        .re    (ctl.ram_re),
        .addr  (ctl.ram_addr),
        .wdata (item.data),
        .rdata (ram_q)
    );

    blkg_ram #(.WIDTH(8), .DEPTH(ROM_BYTES)) u_rom (
        .clk   (clk),
        .we    (ctl.rom_we),
        .re    (ctl.rom_re),
        .addr  (ctl.rom_addr),
        .wdata (item.data),
        .rdata (rom_q)
    );

    always_comb
    begin
        case (s1_src_reg)
            SRC_RAM: read_byte = ram_q;
            SRC_ROM: read_byte = rom_q;
            default: read_byte = BYTE_UNMAPPED;
        endcase
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_src_reg  <= ctl.src;
            s1_flag_reg <= (item.operation == OP_FLAG) ? flag_level : 1'b1;
        end
        if (advance)
        begin
            out_data_reg <= read_byte;
            out_flag_reg <= s1_flag_reg;
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.read_data  = out_data_reg;
    assign rsp.flag_level = out_flag_reg;

    a_accept_fills_stage: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> s1_valid_reg)
        else $error("accepted transaction missing from read stage");

    a_unmapped_reads_ff: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && s1_src_reg == SRC_NONE) |=> rsp.read_data == BYTE_UNMAPPED)
        else $error("response without memory source did not return 0xFF");

    a_rsp_held: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.ready) |=> (rsp.valid && $stable(rsp.read_data)
                                       && $stable(rsp.flag_level)))
        else $error("waiting response transaction changed");

endmodule
